// ----- design/cbts_pkg.sv -----
// Shared constants and types for the CAN bit timing search.
`default_nettype none
package cbts_pkg;

  localparam int unsigned DIV_W   = 36;
  localparam int unsigned CNT_W   = $clog2(DIV_W);
  localparam int unsigned SCORE_W = 43;

  localparam int unsigned SEG1_FLOOR   = 2;
  localparam int unsigned SEG2_FLOOR   = 1;
  localparam int unsigned DATA_S1_MIN  = 2;
  localparam int unsigned DATA_S1_MAX  = 31;
  localparam int unsigned DATA_S2_MIN  = 1;
  localparam int unsigned DATA_S2_MAX  = 16;
  localparam int unsigned DATA_P_MAX   = 32;
  localparam int unsigned HALF_UNIT    = 500;
  localparam int unsigned PER_MILLE    = 1000;

  typedef enum logic [2:0] {
    REG_CLOCK_HZ  = 3'd0,
    REG_SEG1_MIN  = 3'd1,
    REG_SEG1_MAX  = 3'd2,
    REG_SEG2_MIN  = 3'd3,
    REG_SEG2_MAX  = 3'd4,
    REG_PRESC_MIN = 3'd5,
    REG_PRESC_MAX = 3'd6,
    REG_PRESC_STEP = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] clock_hz;
    logic [8:0]  seg1_min;
    logic [8:0]  seg1_max;
    logic [7:0]  seg2_min;
    logic [7:0]  seg2_max;
    logic [10:0] prescaler_min;
    logic [10:0] prescaler_max;
    logic [10:0] prescaler_step;
  } cfg_t;

  typedef struct packed {
    logic        found;
    logic [10:0] prescaler;
    logic [7:0]  phase_one;
    logic [7:0]  phase_two;
  } res_t;

endpackage
`default_nettype wire

// ----- design/can_bit_timing_search.sv -----
// Top level of the CAN bit timing search: registers, handshakes, result register.
//
// Each item (bitrate, sample point, data phase flag) starts a walk over the
// prescalers from the minimum up by the step. Every prescaler tried costs up
// to four divisions on one shared restoring divider that yields one quotient
// bit a cycle, plus segment clamping and scoring. The reset settings walk
// 1024 prescalers and the longest walk covers 2047; a walk that ends early
// (too few quanta) or skips prescalers (too many quanta) does far less work.
// One item is worked at a time; in_stall is high from acceptance until the
// result has moved into the output register, which then holds it for the
// consumer while the next item is taken. Write configuration only while the
// block is idle.
`default_nettype none
module can_bit_timing_search (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [23:0] in_bitrate,
  input  wire logic [9:0]  in_sample_point,
  input  wire logic        in_data_phase,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_found,
  output logic [10:0]      out_prescaler,
  output logic [7:0]       out_phase_one,
  output logic [7:0]       out_phase_two
);
  import cbts_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  res_t res, out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;
  logic busy, res_valid, res_take, in_accept;

  // Register writes; unused bits of the data word drop.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_CLOCK_HZ:   cfg_nxt.clock_hz       = cfg_wdata;
        REG_SEG1_MIN:   cfg_nxt.seg1_min       = cfg_wdata[8:0];
        REG_SEG1_MAX:   cfg_nxt.seg1_max       = cfg_wdata[8:0];
        REG_SEG2_MIN:   cfg_nxt.seg2_min       = cfg_wdata[7:0];
        REG_SEG2_MAX:   cfg_nxt.seg2_max       = cfg_wdata[7:0];
        REG_PRESC_MIN:  cfg_nxt.prescaler_min  = cfg_wdata[10:0];
        REG_PRESC_MAX:  cfg_nxt.prescaler_max  = cfg_wdata[10:0];
        REG_PRESC_STEP: cfg_nxt.prescaler_step = cfg_wdata[10:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  // Accept an item only while the sequencer is idle.
  assign in_stall  = busy;
  assign in_accept = in_valid && !busy;

  cbts_search u_search (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (in_accept),
    .bitrate      (in_bitrate),
    .sample_point (in_sample_point),
    .data_phase   (in_data_phase),
    .cfg          (cfg_r),
    .busy         (busy),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res          (res)
  );

  // Move the result into the output register once it is free or draining.
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_nxt       = res;
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (!rst_n) begin
      out_valid_r          <= 1'b0;
      cfg_r.clock_hz       <= 32'd48000000;
      cfg_r.seg1_min       <= 9'd1;
      cfg_r.seg1_max       <= 9'd16;
      cfg_r.seg2_min       <= 8'd1;
      cfg_r.seg2_max       <= 8'd8;
      cfg_r.prescaler_min  <= 11'd1;
      cfg_r.prescaler_max  <= 11'd1024;
      cfg_r.prescaler_step <= 11'd1;
    end else begin
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_r.found;
  assign out_prescaler = out_r.prescaler;
  assign out_phase_one = out_r.phase_one;
  assign out_phase_two = out_r.phase_two;

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("search did not go busy after an accepted item");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |->
      out_prescaler == 11'd0 && out_phase_one == 8'd0 && out_phase_two == 8'd0)
    else $error("not-found result carries nonzero fields");

  a_found_presc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_prescaler != 11'd0 && out_phase_two != 8'd0)
    else $error("found result with zero prescaler or phase two");
`endif

endmodule
`default_nettype wire

// ----- design/cbts_div.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module cbts_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [cbts_pkg::DIV_W-1:0] num,
  input  wire logic [cbts_pkg::DIV_W-1:0] den,
  output logic                          done,
  output logic [cbts_pkg::DIV_W-1:0]    quo
);
  import cbts_pkg::*;

  logic [DIV_W-1:0] rem_r, rem_nxt, quo_r, quo_nxt, den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [DIV_W:0]   trial;
  logic             ge;

  always_comb begin
    trial    = {rem_r, quo_r[DIV_W-1]};
    ge       = trial >= {1'b0, den_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? DIV_W'(trial - {1'b0, den_r}) : trial[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

// ----- design/cbts_search.sv -----
// Prescaler walk sequencer around the shared serial divider.
`default_nettype none
module cbts_search (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [23:0]     bitrate,
  input  wire logic [9:0]      sample_point,
  input  wire logic            data_phase,
  input  wire cbts_pkg::cfg_t  cfg,
  output logic                 busy,
  output logic                 res_valid,
  input  wire logic            res_take,
  output cbts_pkg::res_t       res
);
  import cbts_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOOP, ST_TQ_START, ST_TQ_WAIT, ST_T1_START, ST_T1_WAIT,
    ST_SEG_A, ST_SEG_B, ST_RATE_START, ST_RATE_WAIT, ST_SP_START, ST_SP_WAIT,
    ST_SCORE, ST_PICK, ST_NEXT, ST_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [23:0]          rate_r, rate_nxt;
  logic [9:0]           sp_r, sp_nxt;
  logic                 data_r, data_nxt;
  logic [11:0]          p_r, p_nxt;
  logic [DIV_W-1:0]     prod_r, prod_nxt, num_r, num_nxt, den_r, den_nxt;
  logic                 start_r, start_nxt;
  logic [9:0]           tq_r, tq_nxt;
  logic [10:0]          t1_r, t1_nxt;
  logic [7:0]           t2_r, t2_nxt;
  logic [31:0]          act_rate_r, act_rate_nxt, rd_r, rd_nxt;
  logic [9:0]           spd_r, spd_nxt;
  logic [SCORE_W-1:0]   score_r, score_nxt, best_r, best_nxt;
  logic                 found_r, found_nxt;
  logic [10:0]          best_p_r, best_p_nxt;
  logic [8:0]           best_s1_r, best_s1_nxt;
  logic [7:0]           best_s2_r, best_s2_nxt;

  logic [8:0]  s1lo, s1hi;
  logic [7:0]  s2lo, s2hi;
  logic [10:0] plo, phi, phi_arb, pinc;
  logic [10:0] tq_min, tq_max;
  logic [10:0] q11, t1a, t1lo, t1c, diff, t2lo, t2c, t1f;
  logic [9:0]  q10;
  logic        div_done;
  logic [DIV_W-1:0] div_quo;

  cbts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Clamps raise to the lower limit first, then cap at the upper one.
  always_comb begin
    s1lo = data_r ? 9'(DATA_S1_MIN) :
           ((cfg.seg1_min < 9'(SEG1_FLOOR)) ? 9'(SEG1_FLOOR) : cfg.seg1_min);
    s1hi = data_r ? 9'(DATA_S1_MAX) :
           ((cfg.seg1_max < 9'(SEG1_FLOOR)) ? 9'(SEG1_FLOOR) : cfg.seg1_max);
    s2lo = data_r ? 8'(DATA_S2_MIN) :
           ((cfg.seg2_min < 8'(SEG2_FLOOR)) ? 8'(SEG2_FLOOR) : cfg.seg2_min);
    s2hi = data_r ? 8'(DATA_S2_MAX) :
           ((cfg.seg2_max < 8'(SEG2_FLOOR)) ? 8'(SEG2_FLOOR) : cfg.seg2_max);
    plo     = (cfg.prescaler_min == '0) ? 11'd1 : cfg.prescaler_min;
    phi_arb = (cfg.prescaler_max == '0) ? 11'd1 : cfg.prescaler_max;
    phi     = (data_r && phi_arb > 11'(DATA_P_MAX)) ? 11'(DATA_P_MAX) : phi_arb;
    pinc    = (cfg.prescaler_step == '0) ? 11'd1 : cfg.prescaler_step;
    tq_min  = 11'd1 + 11'(s1lo) + 11'(s2lo);
    tq_max  = 11'd1 + 11'(s1hi) + 11'(s2hi);
    q11 = div_quo[10:0];
    q10 = div_quo[9:0];
    t1a = (q11 == '0) ? 11'd0 : q11 - 11'd1;
    t1lo = (t1a < 11'(s1lo)) ? 11'(s1lo) : t1a;
    t1c  = (t1lo > 11'(s1hi)) ? 11'(s1hi) : t1lo;
    diff = {1'b0, tq_r} - 11'd1 - t1_r;
    t2lo = (diff < 11'(s2lo)) ? 11'(s2lo) : diff;
    t2c  = (t2lo > 11'(s2hi)) ? 11'(s2hi) : t2lo;
    t1f = {1'b0, tq_r} - 11'd1 - 11'(t2_r);
  end

  always_comb begin
    state_nxt    = state_r;
    rate_nxt     = rate_r;
    sp_nxt       = sp_r;
    data_nxt     = data_r;
    p_nxt        = p_r;
    prod_nxt     = prod_r;
    num_nxt      = num_r;
    den_nxt      = den_r;
    start_nxt    = 1'b0;
    tq_nxt       = tq_r;
    t1_nxt       = t1_r;
    t2_nxt       = t2_r;
    act_rate_nxt = act_rate_r;
    rd_nxt       = rd_r;
    spd_nxt      = spd_r;
    score_nxt    = score_r;
    best_nxt     = best_r;
    found_nxt    = found_r;
    best_p_nxt   = best_p_r;
    best_s1_nxt  = best_s1_r;
    best_s2_nxt  = best_s2_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          rate_nxt    = bitrate;
          sp_nxt      = sample_point;
          data_nxt    = data_phase;
          p_nxt       = 12'(plo);
          found_nxt   = 1'b0;
          best_nxt    = '0;
          best_p_nxt  = '0;
          best_s1_nxt = '0;
          best_s2_nxt = '0;
          state_nxt   = (bitrate == '0 || cfg.clock_hz == '0) ? ST_DONE : ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (p_r > {1'b0, phi}) begin
          state_nxt = ST_DONE;
        end else begin
          prod_nxt  = DIV_W'(p_r) * DIV_W'(rate_r);
          state_nxt = ST_TQ_START;
        end
      end
      ST_TQ_START: begin
        num_nxt   = DIV_W'(cfg.clock_hz) + (prod_r >> 1);
        den_nxt   = prod_r;
        start_nxt = 1'b1;
        state_nxt = ST_TQ_WAIT;
      end
      ST_TQ_WAIT: begin
        if (div_done) begin
          if (div_quo < DIV_W'(tq_min)) begin
            state_nxt = ST_DONE;
          end else if (div_quo > DIV_W'(tq_max)) begin
            state_nxt = ST_NEXT;
          end else begin
            tq_nxt    = q10;
            prod_nxt  = DIV_W'(q10) * DIV_W'(sp_r) + DIV_W'(HALF_UNIT);
            state_nxt = ST_T1_START;
          end
        end
      end
      ST_T1_START: begin
        num_nxt   = prod_r;
        den_nxt   = DIV_W'(PER_MILLE);
        start_nxt = 1'b1;
        state_nxt = ST_T1_WAIT;
      end
      ST_T1_WAIT: begin
        if (div_done) begin
          t1_nxt    = t1c;
          state_nxt = ST_SEG_A;
        end
      end
      ST_SEG_A: begin
        if ({1'b0, tq_r} <= 11'd1 + t1_r) begin
          state_nxt = ST_NEXT;
        end else begin
          t2_nxt    = t2c[7:0];
          state_nxt = ST_SEG_B;
        end
      end
      ST_SEG_B: begin
        if ({1'b0, tq_r} <= 11'd1 + 11'(t2_r) || t1f < 11'(s1lo) || t1f > 11'(s1hi)) begin
          state_nxt = ST_NEXT;
        end else begin
          t1_nxt    = t1f;
          prod_nxt  = DIV_W'(p_r) * DIV_W'(tq_r);
          state_nxt = ST_RATE_START;
        end
      end
      ST_RATE_START: begin
        num_nxt   = DIV_W'(cfg.clock_hz);
        den_nxt   = prod_r;
        start_nxt = 1'b1;
        state_nxt = ST_RATE_WAIT;
      end
      ST_RATE_WAIT: begin
        if (div_done) begin
          act_rate_nxt = div_quo[31:0];
          prod_nxt     = DIV_W'(t1_r + 11'd1) * DIV_W'(PER_MILLE);
          state_nxt    = ST_SP_START;
        end
      end
      ST_SP_START: begin
        num_nxt   = prod_r;
        den_nxt   = DIV_W'(tq_r);
        start_nxt = 1'b1;
        state_nxt = ST_SP_WAIT;
      end
      ST_SP_WAIT: begin
        if (div_done) begin
          spd_nxt = (q10 > sp_r) ? q10 - sp_r : sp_r - q10;
          rd_nxt  = (act_rate_r > {8'd0, rate_r}) ? act_rate_r - {8'd0, rate_r}
                                                  : {8'd0, rate_r} - act_rate_r;
          state_nxt = ST_SCORE;
        end
      end
      ST_SCORE: begin
        score_nxt = SCORE_W'(rd_r) * SCORE_W'(PER_MILLE) + SCORE_W'(spd_r);
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        if (!found_r || score_r < best_r) begin
          found_nxt   = 1'b1;
          best_nxt    = score_r;
          best_p_nxt  = p_r[10:0];
          best_s1_nxt = t1_r[8:0];
          best_s2_nxt = t2_r;
        end
        state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        p_nxt     = p_r + 12'(pinc);
        state_nxt = ST_LOOP;
      end
      ST_DONE: begin
        if (res_take) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rate_r     <= rate_nxt;
    sp_r       <= sp_nxt;
    data_r     <= data_nxt;
    p_r        <= p_nxt;
    prod_r     <= prod_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    tq_r       <= tq_nxt;
    t1_r       <= t1_nxt;
    t2_r       <= t2_nxt;
    act_rate_r <= act_rate_nxt;
    rd_r       <= rd_nxt;
    spd_r      <= spd_nxt;
    score_r    <= score_nxt;
    best_r     <= best_nxt;
    found_r    <= found_nxt;
    best_p_r   <= best_p_nxt;
    best_s1_r  <= best_s1_nxt;
    best_s2_r  <= best_s2_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res.found     = found_r;
  assign res.prescaler = found_r ? best_p_r : 11'd0;
  assign res.phase_one = found_r ? 8'(best_s1_r - 9'd1) : 8'd0;
  assign res.phase_two = found_r ? best_s2_r : 8'd0;

endmodule
`default_nettype wire

// ----- tb/sv/tb_can_bit_timing_search.sv -----
// Self-checking testbench for the CAN bit timing search block.
`default_nettype none
module tb_can_bit_timing_search;
  import cbts_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000000;

  typedef struct {
    logic [23:0] bitrate;
    logic [9:0]  sample_point;
    logic        data_phase;
  } timing_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [23:0] in_bitrate = '0;
  logic [9:0]  in_sample_point = '0;
  logic        in_data_phase = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_found;
  logic [10:0] out_prescaler;
  logic [7:0]  out_phase_one;
  logic [7:0]  out_phase_two;

  // Shadow copy of the configuration registers.
  cfg_t timing_cfg;
  res_t expected_timings[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_receiver = 1'b0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;

  always #1 clk = ~clk;

  can_bit_timing_search DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_bitrate(in_bitrate),
    .in_sample_point(in_sample_point), .in_data_phase(in_data_phase),
    .out_valid(out_valid), .out_stall(out_stall), .out_found(out_found),
    .out_prescaler(out_prescaler), .out_phase_one(out_phase_one),
    .out_phase_two(out_phase_two)
  );

  function automatic longint unsigned raise_to(longint unsigned v, longint unsigned lo);
    return (v < lo) ? lo : v;
  endfunction

  function automatic longint unsigned cap_at(longint unsigned v, longint unsigned hi);
    return (v > hi) ? hi : v;
  endfunction

  function automatic longint unsigned distance(longint unsigned a, longint unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Walk the prescalers and keep the lowest-score timing; first one wins ties.
  function automatic res_t search_timing(timing_req_t req);
    res_t r;
    longint unsigned rate, sp, fclk, s1lo, s1hi, s2lo, s2hi, plo, phi, pinc, p;
    longint unsigned dv, tq, t1, t2, act_rate, act_sp, score, best;
    longint unsigned best_p, best_s1, best_s2;
    bit hit;
    r = '0;
    rate = req.bitrate;
    sp = req.sample_point;
    fclk = timing_cfg.clock_hz;
    hit = 1'b0;
    best = 0; best_p = 0; best_s1 = 0; best_s2 = 0;
    if (rate == 0 || fclk == 0) return r;
    s1lo = req.data_phase ? DATA_S1_MIN : raise_to(timing_cfg.seg1_min, SEG1_FLOOR);
    s1hi = req.data_phase ? DATA_S1_MAX : raise_to(timing_cfg.seg1_max, SEG1_FLOOR);
    s2lo = req.data_phase ? DATA_S2_MIN : raise_to(timing_cfg.seg2_min, SEG2_FLOOR);
    s2hi = req.data_phase ? DATA_S2_MAX : raise_to(timing_cfg.seg2_max, SEG2_FLOOR);
    plo = raise_to(timing_cfg.prescaler_min, 1);
    phi = raise_to(timing_cfg.prescaler_max, 1);
    if (req.data_phase) phi = cap_at(phi, DATA_P_MAX);
    pinc = raise_to(timing_cfg.prescaler_step, 1);
    for (p = plo; p <= phi; p += pinc) begin
      dv = p * rate;
      tq = (fclk + dv / 2) / dv;
      if (tq < 1 + s1lo + s2lo) break;
      if (tq > 1 + s1hi + s2hi) continue;
      t1 = (tq * sp + HALF_UNIT) / PER_MILLE;
      if (t1 < 1) t1 = 1;
      t1 = cap_at(raise_to(t1 - 1, s1lo), s1hi);
      if (tq <= 1 + t1) continue;
      t2 = cap_at(raise_to(tq - 1 - t1, s2lo), s2hi);
      if (tq <= 1 + t2) continue;
      t1 = tq - 1 - t2;
      if (t1 < s1lo || t1 > s1hi) continue;
      act_rate = fclk / (p * tq);
      act_sp = ((1 + t1) * PER_MILLE) / tq;
      score = distance(act_rate, rate) * PER_MILLE + distance(act_sp, sp);
      if (!hit || score < best) begin
        hit = 1'b1;
        best = score;
        best_p = p;
        best_s1 = t1;
        best_s2 = t2;
      end
    end
    if (hit) begin
      r.found = 1'b1;
      r.prescaler = best_p[10:0];
      r.phase_one = 8'(best_s1 - 1);
      r.phase_two = best_s2[7:0];
    end
    return r;
  endfunction

  // Offer one item, predict it, and hold it until accepted.
  task automatic send_request(timing_req_t req);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_bitrate <= req.bitrate;
    in_sample_point <= req.sample_point;
    in_data_phase <= req.data_phase;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_timings.push_back(search_timing(req));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_fields(int unsigned rate, int unsigned sp, bit dp);
    timing_req_t req;
    req.bitrate = rate[23:0];
    req.sample_point = sp[9:0];
    req.data_phase = dp;
    send_request(req);
  endtask

  // Drop valid, wait out every pending result, then a margin for safe writes.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_timings.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_CLOCK_HZ:   timing_cfg.clock_hz = value;
      REG_SEG1_MIN:   timing_cfg.seg1_min = value[8:0];
      REG_SEG1_MAX:   timing_cfg.seg1_max = value[8:0];
      REG_SEG2_MIN:   timing_cfg.seg2_min = value[7:0];
      REG_SEG2_MAX:   timing_cfg.seg2_max = value[7:0];
      REG_PRESC_MIN:  timing_cfg.prescaler_min = value[10:0];
      REG_PRESC_MAX:  timing_cfg.prescaler_max = value[10:0];
      REG_PRESC_STEP: timing_cfg.prescaler_step = value[10:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_config(logic [31:0] fclk, int unsigned s1lo, int unsigned s1hi,
                             int unsigned s2lo, int unsigned s2hi, int unsigned plo,
                             int unsigned phi, int unsigned pinc);
    drain_results();
    write_reg(REG_CLOCK_HZ, fclk);
    write_reg(REG_SEG1_MIN, s1lo);
    write_reg(REG_SEG1_MAX, s1hi);
    write_reg(REG_SEG2_MIN, s2lo);
    write_reg(REG_SEG2_MAX, s2hi);
    write_reg(REG_PRESC_MIN, plo);
    write_reg(REG_PRESC_MAX, phi);
    write_reg(REG_PRESC_STEP, pinc);
    cfg_wr_en <= 1'b0;
  endtask

  // Corner items under the reset configuration and a few edge settings.
  task automatic test_directed();
    send_fields(500000, 875, 0);
    send_fields(1000000, 800, 1);
    send_fields(0, 875, 0);
    send_fields(24'hFFFFFF, 1000, 0);
    send_fields(24'hFFFFFF, 1023, 1);
    send_fields(1, 0, 0);
    send_fields(125000, 500, 0);
    send_fields(2000000, 750, 1);
    send_fields(250000, 1000, 1);
    send_fields(12000000, 0, 0);
    // Zero clock gives no timing; zero prescaler registers behave as one.
    load_config(0, 1, 16, 1, 8, 1, 1024, 1);
    send_fields(500000, 875, 0);
    load_config(32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0);
    send_fields(24'hFFFFFF, 500, 0);
    send_fields(1000000, 875, 1);
    // Wide segment one pushes phase_one past eight bits.
    load_config(80000000, 300, 511, 0, 255, 1, 4, 1);
    send_fields(200000, 900, 0);
    send_fields(150000, 1000, 0);
    // Empty prescaler range.
    load_config(48000000, 1, 16, 1, 8, 40, 10, 3);
    send_fields(500000, 875, 0);
    send_fields(500000, 875, 1);
    load_config(40000000, 2, 256, 1, 128, 1, 2047, 2047);
    send_fields(100000, 700, 0);
    send_fields(5000000, 600, 1);
  endtask

  function automatic timing_req_t random_request();
    timing_req_t req;
    case ($urandom_range(3))
      0: req.bitrate = 24'($urandom);
      1: req.bitrate = 24'($urandom_range(8000000, 20000));
      default: req.bitrate = 24'(125000 << $urandom_range(4));
    endcase
    req.sample_point = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(1000));
    req.data_phase = 1'($urandom_range(1));
    return req;
  endfunction

  // Random items; the configuration is drawn anew every twelve items.
  task automatic test_random(int unsigned count);
    logic [31:0] fclk;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 12 == 0) begin
        fclk = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(80000000, 8000000));
        load_config(fclk, $urandom_range(511), $urandom_range(511), $urandom_range(255),
                    $urandom_range(255), $urandom_range(64), $urandom_range(2047),
                    $urandom_range(2) == 0 ? $urandom_range(2047) : $urandom_range(4));
      end
      send_request(random_request());
    end
  endtask

  // Stall the consumer for a long stretch while items keep coming.
  task automatic test_backpressure();
    drain_results();
    load_config(48000000, 1, 16, 1, 8, 1, 16, 1);
    hold_receiver = 1'b1;
    fork
      begin
        repeat (3000) @(negedge clk);
        hold_receiver = 1'b0;
      end
      for (int unsigned i = 0; i < 4; i++) send_request(random_request());
    join
    drain_results();
  endtask

  // Drive the receiver stall at the falling edge.
  always @(negedge clk)
    out_stall <= hold_receiver || (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);

  // Compare each accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      res_t want;
      results_seen++;
      if (expected_timings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $time);
      end else begin
        want = expected_timings.pop_front();
        if (want.found !== out_found || want.prescaler !== out_prescaler ||
            want.phase_one !== out_phase_one || want.phase_two !== out_phase_two) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d", want.found,
                     want.prescaler, want.phase_one, want.phase_two, out_found,
                     out_prescaler, out_phase_one, out_phase_two);
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_can_bit_timing_search: FAIL");
      $finish;
    end
  end

  initial begin
    timing_cfg = '{clock_hz: 48000000, seg1_min: 1, seg1_max: 16, seg2_min: 1,
                   seg2_max: 8, prescaler_min: 1, prescaler_max: 1024, prescaler_step: 1};
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    send_idle_pct = 26; recv_idle_pct = 65;
    test_random(30);
    test_backpressure();
    send_idle_pct = 65; recv_idle_pct = 26;
    test_random(30);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(20);
    drain_results();
    repeat (100) @(negedge clk);
    if (expected_timings.size() != 0) mismatches++;
    $display("Sent %0d items over directed, random and backpressure phases;", items_sent);
    $display("checked %0d results, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) $display("tb_can_bit_timing_search: PASS");
    else $display("tb_can_bit_timing_search: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
